FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge outside reset.
`define AST_ALWAYS(label, clk_s, rst_s, cond) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (cond)) \
        else $error("assertion failed");
// Antecedent in any cycle implies the consequent in the next.
`define AST_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AST_ALWAYS(label, clk_s, rst_s, cond)
`define AST_NEXT(label, clk_s, rst_s, ante, cons)
`endif
`endif

FILE: hdl/ptq_pkg.sv
// Types and constants of the priority task queue.
package ptq_pkg;

    localparam int HANDLE_W = 8;
    localparam int PRIO_W   = 8;
    localparam int COUNT_OUT_W = 5;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // one queue slot
    typedef struct packed {
        logic                used;
        logic [HANDLE_W-1:0] handle;
        logic [PRIO_W-1:0]   prio;
    } ptq_entry_t;

    // broadcast to every cell for the current word
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [HANDLE_W-1:0] new_handle;
        logic [PRIO_W-1:0]   new_prio;
    } ptq_ctrl_t;

endpackage

FILE: hdl/priority_task_queue_core.sv
// Top level of the priority task queue: cell chain, counters and result word.
//
// Usage:
//   Command channel: drive opcode, task_handle and priority_req and raise
//   start; the word is taken at the clock edge where start is high and busy
//   is low. busy stays low, so a new word may be issued every cycle.
//   Push (opcode 0) inserts the entry ahead of the first queued entry whose
//   priority is not lower; pop (opcode 1) removes the head entry.
//   Result channel: in the cycle after a word is taken, done pulses for one
//   cycle with out_valid, out_handle, out_priority, occupancy,
//   peak_occupancy and overflow. The receiver cannot stall; a result must
//   be sampled in its done cycle.
//   Throughput is one word per cycle: every slot is a cell that compares
//   against the broadcast priority and shifts from its neighbor in the
//   same cycle, so an insert or removal finishes at once.
//   A push into a full queue is dropped and sets the sticky overflow flag.
//   Reset empties the queue and clears the counts, the flag and done.
`include "assert_macros.svh"
module priority_task_queue_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          opcode,
    input  logic [ptq_pkg::HANDLE_W-1:0]  task_handle,
    input  logic [ptq_pkg::PRIO_W-1:0]    priority_req,
    output logic                          done,
    output logic                          out_valid,
    output logic [ptq_pkg::HANDLE_W-1:0]  out_handle,
    output logic [ptq_pkg::PRIO_W-1:0]    out_priority,
    output logic [ptq_pkg::COUNT_OUT_W-1:0] occupancy,
    output logic [ptq_pkg::COUNT_OUT_W-1:0] peak_occupancy,
    output logic                          overflow
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    logic                 accept;
    logic                 is_full;
    logic                 is_empty;
    logic                 push_on_full;
    ptq_pkg::ptq_ctrl_t   ctrl;
    ptq_pkg::ptq_entry_t  cell_entry [QUEUE_DEPTH];
    logic                 cell_keep  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] used_vec;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [CNT_W-1:0]     peak_reg;
    logic [CNT_W-1:0]     peak_next;
    logic                 overflow_reg;
    logic                 overflow_next;
    logic                 done_reg;
    logic                 valid_reg;
    logic                 valid_next;
    logic [ptq_pkg::HANDLE_W-1:0] handle_reg;
    logic [ptq_pkg::HANDLE_W-1:0] handle_next;
    logic [ptq_pkg::PRIO_W-1:0]   prio_reg;
    logic [ptq_pkg::PRIO_W-1:0]   prio_next;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign is_full  = (count_reg == FULL_CNT);
    assign is_empty = (count_reg == '0);
    assign push_on_full = accept && (opcode == ptq_pkg::OP_PUSH) && is_full;

    assign ctrl.push       = accept && (opcode == ptq_pkg::OP_PUSH) && !is_full;
    assign ctrl.pop        = accept && (opcode == ptq_pkg::OP_POP) && !is_empty;
    assign ctrl.new_handle = task_handle;
    assign ctrl.new_prio   = priority_req;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            ptq_pkg::ptq_entry_t left_e;
            ptq_pkg::ptq_entry_t right_e;
            logic                left_k;

            if (gi == 0)
            begin : g_head
                assign left_e = '0;
                assign left_k = 1'b1;
            end
            else
            begin : g_body
                assign left_e = cell_entry[gi-1];
                assign left_k = cell_keep[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_e = '0;
            end
            else
            begin : g_mid
                assign right_e = cell_entry[gi+1];
            end

            ptq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .left_entry  (left_e),
                .left_keep   (left_k),
                .right_entry (right_e),
                .entry       (cell_entry[gi]),
                .keep        (cell_keep[gi])
            );

            assign used_vec[gi] = cell_entry[gi].used;
        end
    endgenerate

    always_comb
    begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        valid_next    = 1'b0;
        handle_next   = '0;
        prio_next     = '0;
        if (ctrl.push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.pop)
        begin
            count_next  = count_reg - 1'b1;
            valid_next  = 1'b1;
            handle_next = cell_entry[0].handle;
            prio_next   = cell_entry[0].prio;
        end
        if (push_on_full)
        begin
            overflow_next = 1'b1;
        end
        peak_next = (count_next > peak_reg) ? count_next : peak_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            peak_reg     <= '0;
            overflow_reg <= 1'b0;
            done_reg     <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            peak_reg     <= peak_next;
            overflow_reg <= overflow_next;
            done_reg     <= accept;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        handle_reg <= handle_next;
        prio_reg   <= prio_next;
    end

    assign done           = done_reg;
    assign out_valid      = valid_reg;
    assign out_handle     = handle_reg;
    assign out_priority   = prio_reg;
    assign occupancy      = ptq_pkg::COUNT_OUT_W'(count_reg);
    assign peak_occupancy = ptq_pkg::COUNT_OUT_W'(peak_reg);
    assign overflow       = overflow_reg;

    `AST_ALWAYS(a_count_bound, clk, rst_n, count_reg <= FULL_CNT)
    `AST_ALWAYS(a_peak_ge_count, clk, rst_n, peak_reg >= count_reg)
    `AST_ALWAYS(a_used_matches_count, clk, rst_n, CNT_W'($countones(used_vec)) == count_reg)
    `AST_NEXT(a_full_push_flags, clk, rst_n, push_on_full, overflow_reg && $stable(count_reg))

endmodule

FILE: hdl/ptq_cell.sv
// One slot of the sorted queue chain.
module ptq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  ptq_pkg::ptq_ctrl_t  ctrl,
    input  ptq_pkg::ptq_entry_t left_entry,
    input  logic                left_keep,
    input  ptq_pkg::ptq_entry_t right_entry,
    output ptq_pkg::ptq_entry_t entry,
    output logic                keep
);

    logic                        used_reg;
    logic                        used_next;
    logic [ptq_pkg::HANDLE_W-1:0] handle_reg;
    logic [ptq_pkg::HANDLE_W-1:0] handle_next;
    logic [ptq_pkg::PRIO_W-1:0]   prio_reg;
    logic [ptq_pkg::PRIO_W-1:0]   prio_next;

    // entries ahead of the insertion point stay put
    assign keep = used_reg && (prio_reg < ctrl.new_prio);

    assign entry.used   = used_reg;
    assign entry.handle = handle_reg;
    assign entry.prio   = prio_reg;

    always_comb
    begin
        used_next   = used_reg;
        handle_next = handle_reg;
        prio_next   = prio_reg;
        if (ctrl.pop)
        begin
            used_next   = right_entry.used;
            handle_next = right_entry.handle;
            prio_next   = right_entry.prio;
        end
        else if (ctrl.push && !keep)
        begin
            if (left_keep)
            begin
                used_next   = 1'b1;
                handle_next = ctrl.new_handle;
                prio_next   = ctrl.new_prio;
            end
            else
            begin
                used_next   = left_entry.used;
                handle_next = left_entry.handle;
                prio_next   = left_entry.prio;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        handle_reg <= handle_next;
        prio_reg   <= prio_next;
    end

endmodule
